// ===== hdl/acgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acgr_pkg: shared types and constants of the compressor gain ramp
// Field widths, register indexes, reset values, zone constants and the
// command record that the front hands to the back through the queue.
// ----------------------------------------------------------------------------
package acgr_pkg;

    localparam int PEAK_W          = 17;
    localparam int GAIN_W          = 16;
    localparam int DELAY_W         = 6;
    localparam int STEP_W          = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 24;

    localparam int LEVEL_FRAC_BITS = 16;
    localparam int GAIN_FRAC_BITS  = 12;

    // divider: width fits a threshold shifted up by the gain fraction bits
    localparam int DIV_W           = PEAK_W + GAIN_FRAC_BITS;
    localparam int DIV_CNT_W       = $clog2(DIV_W);
    // lower zone quotient: num / (peak * 2^(LEVEL-GAIN)) == (num >> shift) / peak
    localparam int NUM_SHIFT       = LEVEL_FRAC_BITS - GAIN_FRAC_BITS;
    localparam int PROD_A_W        = 2 * (PEAK_W + 1);
    localparam int PROD_B_W        = 2 * PEAK_W;
    localparam int NUM_W           = PROD_A_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 2'd2;

    localparam logic [PEAK_W-1:0] UPPER_RST = 17'd26214;
    localparam logic [PEAK_W-1:0] LOWER_RST = 17'd3277;
    localparam logic [PEAK_W-1:0] SLOPE_RST = 17'd0;
    localparam logic [PEAK_W:0]   LEVEL_ONE = 18'(1 << LEVEL_FRAC_BITS);

    localparam logic [GAIN_W-1:0]  GAIN_UNITY = 16'(1 << GAIN_FRAC_BITS);
    localparam logic [GAIN_W-1:0]  GAIN_CAP   = 16'(10 << GAIN_FRAC_BITS);
    localparam logic [DELAY_W-1:0] MID_DELAY  = 6'd50;
    localparam logic [STEP_W-1:0]  MID_LAST   = 5'd19;
    localparam logic [STEP_W-1:0]  LOW_LAST   = 5'd1;

    // ramp step: |diff| * i, then divide by 2 or by 20
    localparam int RAMP_PROD_W   = GAIN_W + STEP_W;
    localparam int DIV5_RECIP_W  = 20;
    localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 20'd838861; // ceil(2^22 / 5)
    localparam int DIV5_SHIFT    = 22;
    localparam int RECIP_PROD_W  = RAMP_PROD_W - 2 + DIV5_RECIP_W;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [GAIN_W-1:0] target;
        logic              mid;     // 1: 20 steps, 50 ms; 0: 2 steps, no delay
    } t_ramp_cmd;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [PEAK_W-1:0]    data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PROD,
        F_SUM,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_SCALE,
        B_EMIT
    } t_back_state;

endpackage
`default_nettype wire

// ===== hdl/audio_compressor_gain_ramp_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_compressor_gain_ramp_top: compressor / limiter gain ramp generator
// Turns each measured peak level into a ramp of mixer gain steps.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one peak level per beat (tdata[16:0]). For each peak the
//   block sorts the level into limiter, unity or lower compression zone,
//   works out a target gain and sends a ramp of 2 or 20 gain beats on
//   m_axis (tdata[15:0] gain Q4.12, tdata[21:16] step delay in ms, tlast on
//   the final step of the ramp).
//   The cfg channel writes the upper threshold, lower threshold and slope
//   (index 0, 1, 2; other indexes are dropped); it is always ready. It is to be
//   written only while the block is idle: the user must keep to this, the block
//   itself does not enforce it. A unity-zone or zero peak goes straight to
//   the queue; a limiter peak and a lower-zone peak need the serial divider,
//   the lower-zone peak after a product and a sum. The back pops a command,
//   then works each gain step as multiply, scale and add. A queue of
//   QUEUE_DEPTH commands lets the front take and divide the next peaks while
//   the back ramps, so a steady stream is paced by the slower of the two.
//   Reset restores the register defaults, unity gain and the 2-step mode.
//   A stalled m_axis holds the current beat; the back waits, then the queue
//   fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module audio_compressor_gain_ramp_top #(
    parameter int QUEUE_DEPTH = acgr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [acgr_pkg::S_TDATA_W-1:0]      s_axis_tdata,   // [16:0] peak_level
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [acgr_pkg::M_TDATA_W-1:0]           m_axis_tdata,   // [15:0] gain_value,
                                                                     // [21:16] step_delay_ms
    output logic                                     m_axis_tlast,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [acgr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [acgr_pkg::PEAK_W-1:0]         i_cfg_data
);

    acgr_pkg::t_cfg_wr               cfg_wr;
    acgr_pkg::t_ramp_cmd             push_cmd;
    acgr_pkg::t_ramp_cmd             pop_cmd;
    logic                            push;
    logic                            pop;
    logic                            q_full;
    logic                            q_empty;
    logic [acgr_pkg::GAIN_W-1:0]     gain;
    logic [acgr_pkg::DELAY_W-1:0]    delay;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = '{valid: i_cfg_valid, index: i_cfg_index, data: i_cfg_data};

    acgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_wr),
        .i_peak_valid (s_axis_tvalid),
        .o_peak_ready (s_axis_tready),
        .i_peak       (s_axis_tdata[acgr_pkg::PEAK_W-1:0]),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_full       (q_full)
    );

    acgr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_cmd),
        .o_full    (q_full),
        .i_pop     (pop),
        .o_rd_data (pop_cmd),
        .o_empty   (q_empty)
    );

    acgr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pop_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_gain  (gain),
        .o_delay (delay),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(acgr_pkg::M_TDATA_W - acgr_pkg::GAIN_W - acgr_pkg::DELAY_W){1'b0}},
                           delay, gain};

endmodule
`default_nettype wire

// ===== hdl/acgr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acgr_div: iterative restoring divider
// One quotient bit per cycle; a done pulse follows the last bit.
// ----------------------------------------------------------------------------
module acgr_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [acgr_pkg::DIV_W-1:0]       i_dividend,
    input  wire logic [acgr_pkg::PEAK_W-1:0]      i_divisor,
    output logic                                  o_done,
    output logic [acgr_pkg::DIV_W-1:0]            o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [acgr_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [acgr_pkg::DIV_W-1:0]       r_quo;
    logic [acgr_pkg::PEAK_W-1:0]      r_rem;
    logic [acgr_pkg::PEAK_W-1:0]      r_dvs;

    logic [acgr_pkg::PEAK_W:0]        shifted;
    logic                             q_bit;
    logic [acgr_pkg::PEAK_W:0]        trial;

    always_comb begin
        shifted = {r_rem, r_quo[acgr_pkg::DIV_W-1]};
        q_bit   = (shifted >= {1'b0, r_dvs});
        trial   = q_bit ? (shifted - {1'b0, r_dvs}) : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= acgr_pkg::DIV_CNT_W'(acgr_pkg::DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the top bit drops out
            r_rem <= trial[acgr_pkg::PEAK_W-1:0];
            r_quo <= {r_quo[acgr_pkg::DIV_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== hdl/acgr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acgr_fifo: short command queue between front and back
// Holds ramp commands; the writer checks full, the reader checks empty.
// ----------------------------------------------------------------------------
module acgr_fifo #(
    parameter int DEPTH = acgr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  acgr_pkg::t_ramp_cmd      i_wr_data,
    output logic                     o_full,
    input  wire logic                i_pop,
    output acgr_pkg::t_ramp_cmd      o_rd_data,
    output logic                     o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    acgr_pkg::t_ramp_cmd r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/acgr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acgr_front: peak classifier and target gain unit
// Holds the threshold registers and the ramp mode, sorts each peak into a
// zone, works out the target gain and queues a ramp command.
// ----------------------------------------------------------------------------
module acgr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  acgr_pkg::t_cfg_wr                  i_cfg,
    input  wire logic                          i_peak_valid,
    output logic                               o_peak_ready,
    input  wire logic [acgr_pkg::PEAK_W-1:0]   i_peak,
    output logic                               o_push,
    output acgr_pkg::t_ramp_cmd                o_cmd,
    input  wire logic                          i_full
);

    acgr_pkg::t_front_state                r_state, n_state;
    logic [acgr_pkg::PEAK_W-1:0]           r_upper;
    logic [acgr_pkg::PEAK_W-1:0]           r_lower;
    logic [acgr_pkg::PEAK_W-1:0]           r_slope;
    logic                                  r_mid, n_mid;
    logic [acgr_pkg::PEAK_W-1:0]           r_peak, n_peak;
    logic [acgr_pkg::GAIN_W-1:0]           r_target, n_target;
    logic                                  r_upper_zone, n_upper_zone;
    logic signed [acgr_pkg::PROD_A_W-1:0]  r_prod_a;
    logic [acgr_pkg::PROD_B_W-1:0]         r_prod_b;

    logic signed [acgr_pkg::NUM_W-1:0]     num;
    logic                                  div_start;
    logic [acgr_pkg::DIV_W-1:0]            div_dividend;
    logic [acgr_pkg::PEAK_W-1:0]           div_divisor;
    logic                                  div_done;
    logic [acgr_pkg::DIV_W-1:0]            div_quotient;

    acgr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // lower zone numerator: lower * (1 - slope) + slope * peak
    assign num = $signed({r_prod_a[acgr_pkg::PROD_A_W-1], r_prod_a})
               + $signed({{(acgr_pkg::NUM_W - acgr_pkg::PROD_B_W){1'b0}}, r_prod_b});

    assign o_peak_ready = (r_state == acgr_pkg::F_IDLE);
    assign o_cmd        = '{target: r_target, mid: r_mid};

    always_comb begin
        n_state      = r_state;
        n_mid        = r_mid;
        n_peak       = r_peak;
        n_target     = r_target;
        n_upper_zone = r_upper_zone;
        div_start    = 1'b0;
        div_dividend = {r_upper, {acgr_pkg::GAIN_FRAC_BITS{1'b0}}};
        div_divisor  = i_peak;
        o_push       = 1'b0;
        unique case (r_state)
            acgr_pkg::F_IDLE: begin
                if (i_peak_valid) begin
                    n_peak = i_peak;
                    if (i_peak > r_upper) begin
                        // hard limiter: upper / peak, ramp mode kept
                        n_upper_zone = 1'b1;
                        div_start    = 1'b1;
                        n_state      = acgr_pkg::F_DIV;
                    end else if (i_peak > r_lower) begin
                        n_upper_zone = 1'b0;
                        n_mid        = 1'b1;
                        n_target     = acgr_pkg::GAIN_UNITY;
                        n_state      = acgr_pkg::F_PUSH;
                    end else begin
                        n_upper_zone = 1'b0;
                        n_mid        = 1'b0;
                        if (i_peak == '0) begin
                            n_target = acgr_pkg::GAIN_CAP;
                            n_state  = acgr_pkg::F_PUSH;
                        end else begin
                            n_state  = acgr_pkg::F_PROD;
                        end
                    end
                end
            end
            acgr_pkg::F_PROD: begin
                n_state = acgr_pkg::F_SUM;
            end
            acgr_pkg::F_SUM: begin
                div_dividend = num[acgr_pkg::NUM_SHIFT +: acgr_pkg::DIV_W];
                div_divisor  = r_peak;
                if (num[acgr_pkg::NUM_W-1] || (num == '0)) begin
                    n_target = '0;
                    n_state  = acgr_pkg::F_PUSH;
                end else begin
                    div_start = 1'b1;
                    n_state   = acgr_pkg::F_DIV;
                end
            end
            acgr_pkg::F_DIV: begin
                if (div_done) begin
                    if (!r_upper_zone && (div_quotient > acgr_pkg::DIV_W'(acgr_pkg::GAIN_CAP))) begin
                        n_target = acgr_pkg::GAIN_CAP;
                    end else begin
                        n_target = div_quotient[acgr_pkg::GAIN_W-1:0];
                    end
                    n_state = acgr_pkg::F_PUSH;
                end
            end
            acgr_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = acgr_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = acgr_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acgr_pkg::F_IDLE;
            r_mid   <= 1'b0;
            r_upper <= acgr_pkg::UPPER_RST;
            r_lower <= acgr_pkg::LOWER_RST;
            r_slope <= acgr_pkg::SLOPE_RST;
        end else begin
            r_state <= n_state;
            r_mid   <= n_mid;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    acgr_pkg::REG_UPPER: r_upper <= i_cfg.data;
                    acgr_pkg::REG_LOWER: r_lower <= i_cfg.data;
                    acgr_pkg::REG_SLOPE: r_slope <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_peak       <= n_peak;
        r_target     <= n_target;
        r_upper_zone <= n_upper_zone;
        r_prod_a     <= $signed({1'b0, r_lower}) * $signed(acgr_pkg::LEVEL_ONE - {1'b0, r_slope});
        r_prod_b     <= r_slope * r_peak;
    end

endmodule
`default_nettype wire

// ===== hdl/acgr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acgr_back: gain ramp sequencer
// Pops a ramp command and walks its steps: prev + (target - prev) * i / n,
// each step through multiply, scale and emit states, into an output register.
// ----------------------------------------------------------------------------
module acgr_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  acgr_pkg::t_ramp_cmd                 i_cmd,
    input  wire logic                           i_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [acgr_pkg::GAIN_W-1:0]         o_gain,
    output logic [acgr_pkg::DELAY_W-1:0]        o_delay,
    output logic                                o_last
);

    acgr_pkg::t_back_state                    r_state, n_state;
    logic [acgr_pkg::GAIN_W-1:0]              r_gain, n_gain;
    logic [acgr_pkg::STEP_W-1:0]              r_step, n_step;
    logic                                     r_out_valid, n_out_valid;
    logic [acgr_pkg::GAIN_W-1:0]              r_target;
    logic                                     r_mid;
    logic                                     r_neg;
    logic [acgr_pkg::RAMP_PROD_W-1:0]         r_prod;
    logic [acgr_pkg::GAIN_W-1:0]              r_q;
    logic [acgr_pkg::GAIN_W-1:0]              r_out_gain;
    logic [acgr_pkg::DELAY_W-1:0]             r_out_delay;
    logic                                     r_out_last;

    logic                                     neg;
    logic [acgr_pkg::GAIN_W-1:0]              mag;
    logic [acgr_pkg::RECIP_PROD_W-1:0]        recip_prod;
    logic [acgr_pkg::GAIN_W-1:0]              step_gain;
    logic [acgr_pkg::STEP_W-1:0]              last_idx;
    logic                                     load_out;

    always_comb begin
        neg        = (r_gain > r_target);
        mag        = neg ? (r_gain - r_target) : (r_target - r_gain);
        // divide by 20 as (p / 4) / 5 through the reciprocal of 5
        recip_prod = acgr_pkg::RECIP_PROD_W'(r_prod[acgr_pkg::RAMP_PROD_W-1:2])
                   * acgr_pkg::RECIP_PROD_W'(acgr_pkg::DIV5_RECIP);
        step_gain  = r_neg ? (r_gain - r_q) : (r_gain + r_q);
        last_idx   = r_mid ? acgr_pkg::MID_LAST : acgr_pkg::LOW_LAST;
    end

    always_comb begin
        n_state     = r_state;
        n_gain      = r_gain;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        load_out    = 1'b0;
        o_pop       = 1'b0;
        unique case (r_state)
            acgr_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_step  = '0;
                    n_state = acgr_pkg::B_MUL;
                end
            end
            acgr_pkg::B_MUL: begin
                n_state = acgr_pkg::B_SCALE;
            end
            acgr_pkg::B_SCALE: begin
                n_state = acgr_pkg::B_EMIT;
            end
            acgr_pkg::B_EMIT: begin
                // hold the step until the output register frees up
                if (!r_out_valid || i_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_gain      = step_gain;
                    if (r_step == last_idx) begin
                        n_state = acgr_pkg::B_IDLE;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = acgr_pkg::B_MUL;
                    end
                end
            end
            default: begin
                n_state = acgr_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acgr_pkg::B_IDLE;
            r_gain      <= acgr_pkg::GAIN_UNITY;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gain      <= n_gain;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_target <= i_cmd.target;
            r_mid    <= i_cmd.mid;
        end
        if (r_state == acgr_pkg::B_MUL) begin
            r_neg  <= neg;
            r_prod <= acgr_pkg::RAMP_PROD_W'(mag) * acgr_pkg::RAMP_PROD_W'(r_step);
        end
        if (r_state == acgr_pkg::B_SCALE) begin
            r_q <= r_mid ? recip_prod[acgr_pkg::DIV5_SHIFT +: acgr_pkg::GAIN_W]
                         : r_prod[1 +: acgr_pkg::GAIN_W];
        end
        if (load_out) begin
            r_out_gain  <= step_gain;
            r_out_delay <= r_mid ? acgr_pkg::MID_DELAY : '0;
            r_out_last  <= (r_step == last_idx);
        end
    end

    assign o_valid = r_out_valid;
    assign o_gain  = r_out_gain;
    assign o_delay = r_out_delay;
    assign o_last  = r_out_last;

endmodule
`default_nettype wire

// ===== hdl/acgr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acgr_checker: port-level checks of the gain ramp block
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module acgr_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [acgr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                                m_axis_tlast
);

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // step delay is either none or the unity-zone delay
    a_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[acgr_pkg::GAIN_W +: acgr_pkg::DELAY_W] == '0) ||
            (m_axis_tdata[acgr_pkg::GAIN_W +: acgr_pkg::DELAY_W] == acgr_pkg::MID_DELAY))
        else $error("step delay out of range");

    // every step lies between two gains that never exceed the cap
    a_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[acgr_pkg::GAIN_W-1:0] <= acgr_pkg::GAIN_CAP))
        else $error("gain above cap");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind audio_compressor_gain_ramp_top acgr_checker u_acgr_checker (.*);
`default_nettype wire

// ===== verif/tb_audio_compressor_gain_ramp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_compressor_gain_ramp_top: self-checking bench of the gain ramp
// Streams peak levels into the block under several threshold and slope
// settings, predicts every gain step of every ramp and compares each output
// beat with the oldest predicted step. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_audio_compressor_gain_ramp_top;
    import acgr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;   // unmapped index, write is dropped
    localparam int    MID_STEPS    = 20;
    localparam int    LOW_STEPS    = 2;
    localparam int    RX_HOLD_LEN  = 600;
    localparam int    TAIL_CYCLES  = 120;
    localparam int    PHASES       = 9;
    localparam int    PHASE_ITEMS  = 45;
    localparam int    PEAK_MAX     = (1 << PEAK_W) - 1;

    typedef struct {
        logic [GAIN_W-1:0]  gain;
        logic [DELAY_W-1:0] delay;
        logic               last;
    } ramp_step_t;

    // Shadow of the registers and ramp state, plus the steps still to come.
    class gain_ramp_board;
        logic [PEAK_W-1:0]  upper_thr;
        logic [PEAK_W-1:0]  lower_thr;
        logic [PEAK_W-1:0]  slope;
        logic [GAIN_W-1:0]  cur_gain;
        int                 steps;
        logic [DELAY_W-1:0] step_delay;
        ramp_step_t         due_steps[$];
        int                 errors;

        function new();
            upper_thr  = UPPER_RST;
            lower_thr  = LOWER_RST;
            slope      = SLOPE_RST;
            cur_gain   = GAIN_UNITY;
            steps      = LOW_STEPS;
            step_delay = '0;
            errors     = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PEAK_W-1:0] val);
            case (idx)
                REG_UPPER: upper_thr = val;
                REG_LOWER: lower_thr = val;
                REG_SLOPE: slope     = val;
                default: ;
            endcase
        endfunction

        function void note_peak(input logic [PEAK_W-1:0] peak);
            logic [GAIN_W-1:0] target;
            longint            num;
            longint            diff;
            longint            g;
            ramp_step_t        st;
            if (peak > upper_thr) begin
                // hard limiter: ramp length and delay stay as they were
                target = GAIN_W'((longint'(upper_thr) << GAIN_FRAC_BITS) / longint'(peak));
            end else if (peak > lower_thr) begin
                target     = GAIN_UNITY;
                steps      = MID_STEPS;
                step_delay = MID_DELAY;
            end else begin
                steps      = LOW_STEPS;
                step_delay = '0;
                num = longint'(lower_thr) * ((longint'(1) << LEVEL_FRAC_BITS) - longint'(slope))
                    + longint'(slope) * longint'(peak);
                if (peak == 0) begin
                    target = GAIN_CAP;
                end else if (num <= 0) begin
                    target = '0;
                end else begin
                    num = (num << GAIN_FRAC_BITS) / (longint'(peak) << LEVEL_FRAC_BITS);
                    target = (num > longint'(GAIN_CAP)) ? GAIN_CAP : GAIN_W'(num);
                end
            end
            for (int i = 0; i < steps; i++) begin
                diff = longint'(target) - longint'(cur_gain);
                g    = longint'(cur_gain) + (diff * longint'(i)) / longint'(steps);
                if (g < 0)
                    g = 0;
                cur_gain = g[GAIN_W-1:0];
                st.gain  = cur_gain;
                st.delay = step_delay;
                st.last  = (i + 1 == steps);
                due_steps.push_back(st);
            end
        endfunction

        function void check_step(input logic [GAIN_W-1:0] gain, input logic [DELAY_W-1:0] delay,
                                 input logic last);
            ramp_step_t st;
            if (due_steps.size() == 0) begin
                $error("gain beat with none pending: gain_value %0d", gain);
                errors++;
            end else begin
                st = due_steps.pop_front();
                if (gain !== st.gain) begin
                    $error("gain_value: expected %0d, actual %0d", st.gain, gain);
                    errors++;
                end
                if (delay !== st.delay) begin
                    $error("step_delay_ms: expected %0d, actual %0d", st.delay, delay);
                    errors++;
                end
                if (last !== st.last) begin
                    $error("last_step: expected %0d, actual %0d", st.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 s_valid    = 1'b0;
    logic [S_TDATA_W-1:0] s_data     = '0;
    logic                 m_ready    = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [PEAK_W-1:0]    cfg_data   = '0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 o_cfg_ready;

    gain_ramp_board board;
    bit             quiet       = 1'b0;   // no idling on either side
    bit             no_gaps     = 1'b0;   // sender offers back to back
    int             hold_ticket = 0;
    int             hold_seen   = 0;
    int             hold_left   = 0;

    audio_compressor_gain_ramp_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),          // [16:0] peak_level
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),    // [15:0] gain_value, [21:16] step_delay_ms
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random backpressure, or a long hold when one is requested.
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = RX_HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 18);
        end
    end

    // Monitor: every handshake is sampled at the edge that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_valid && s_axis_tready)
                board.note_peak(s_data[PEAK_W-1:0]);
            if (m_axis_tvalid && m_ready)
                board.check_step(m_axis_tdata[GAIN_W-1:0],
                                 m_axis_tdata[GAIN_W +: DELAY_W], m_axis_tlast);
        end
    end

    task automatic send_peak(input logic [PEAK_W-1:0] peak);
        int gap;
        gap = (quiet || no_gaps) ? 0 : (($urandom_range(0, 99) < 18) ? $urandom_range(1, 6) : 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= S_TDATA_W'(peak);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering and hold until every predicted step has come out.
    task automatic drain_ramps();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (board.due_steps.size() != 0);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [PEAK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_thresholds(input logic [PEAK_W-1:0] upper, input logic [PEAK_W-1:0] lower,
                                   input logic [PEAK_W-1:0] slp, input bit junk);
        drain_ramps();
        cfg_beat(REG_UPPER, upper);
        cfg_beat(REG_LOWER, lower);
        cfg_beat(REG_SLOPE, slp);
        if (junk)
            cfg_beat(REG_NONE, PEAK_W'($urandom_range(0, PEAK_MAX)));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PEAK_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return PEAK_W'(655);
            2:       return PEAK_W'(65536);
            default: return PEAK_W'(PEAK_MAX);
        endcase
    endfunction

    function automatic logic [PEAK_W-1:0] near(input logic [PEAK_W-1:0] thr);
        int v;
        v = int'(thr) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > PEAK_MAX)
            v = PEAK_MAX;
        return PEAK_W'(v);
    endfunction

    function automatic logic [PEAK_W-1:0] pick_peak();
        case ($urandom_range(0, 9))
            0:       return PEAK_W'($urandom_range(0, 1));
            1, 2:    return near(board.upper_thr);
            3, 4:    return near(board.lower_thr);
            8:       return PEAK_W'($urandom_range(0, PEAK_MAX));
            9:       return PEAK_W'($urandom_range(0, 1000));
            default: return PEAK_W'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        logic [PEAK_W-1:0] up;
        logic [PEAK_W-1:0] lo;
        logic [PEAK_W-1:0] sl;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // limiter straight after reset keeps the 2-step mode, then zone edges
        send_peak(40000);
        send_peak(26215);
        send_peak(26214);
        send_peak(3278);
        send_peak(65536);
        send_peak(PEAK_MAX);
        send_peak(3277);
        send_peak(0);
        send_peak(1);
        send_peak(327);
        send_peak(500);

        // slope of exactly one: lower-zone target is unity
        load_thresholds(PEAK_MAX, 65536, 65536, 1'b0);
        send_peak(100);
        send_peak(65536);
        send_peak(70000);
        send_peak(PEAK_MAX);

        // slope above one: numerator goes negative for small peaks
        load_thresholds(PEAK_MAX, 65536, PEAK_MAX, 1'b1);
        send_peak(1);
        send_peak(65536);
        send_peak(0);

        // reversed thresholds: no middle zone
        load_thresholds(655, PEAK_MAX, 0, 1'b0);
        send_peak(600);
        send_peak(655);
        send_peak(656);
        send_peak(0);

        load_thresholds(0, 0, 0, 1'b0);
        send_peak(0);
        send_peak(1);

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: begin
                    up = PEAK_W'($urandom_range(655, 65536));
                    lo = PEAK_W'($urandom_range(655, 65536));
                    sl = PEAK_W'($urandom_range(0, 65536));
                end
                1: begin
                    lo = PEAK_W'($urandom_range(655, 30000));
                    up = PEAK_W'($urandom_range(int'(lo) + 1, 65536));
                    sl = PEAK_W'($urandom_range(0, 65536));
                end
                2: begin
                    up = PEAK_W'($urandom_range(0, PEAK_MAX));
                    lo = PEAK_W'($urandom_range(0, PEAK_MAX));
                    sl = PEAK_W'($urandom_range(0, PEAK_MAX));
                end
                3: begin
                    up = pick_extreme();
                    lo = pick_extreme();
                    sl = pick_extreme();
                end
                default: begin
                    up = UPPER_RST;
                    lo = LOWER_RST;
                    sl = PEAK_W'($urandom_range(0, 65536));
                end
            endcase
            load_thresholds(up, lo, sl, $urandom_range(0, 3) == 0);
            quiet   = (ph == 2);
            no_gaps = (ph == 4);
            // fill the block against a stalled receiver
            if (ph == 4)
                hold_ticket++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (!no_gaps && $urandom_range(0, 29) == 0)
                    drain_ramps();
                send_peak(pick_peak());
            end
        end
        quiet   = 1'b0;
        no_gaps = 1'b0;

        drain_ramps();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.due_steps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
